### hdl/dnd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared constants, codes and disc geometry for the neighbourhood
// dissimilarity block.
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_MAX_RADIUS  = 4;
    localparam int DEF_MARKER_BITS = 16;

    // coordinate registers hold up to 255, dimensions up to 256
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int OFS_W   = 4;    // signed disc offset, -4..4
    localparam int RAD_W   = 3;
    localparam int CNT_W   = 6;    // disc cell count, up to 49
    localparam int SUMX_W  = 6;    // growth of the sum over 48 neighbours

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_RADIUS = 2'd2;

    localparam logic [1:0] FUNC_WRITE        = 2'd0;
    localparam logic [1:0] FUNC_WRITE_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_UPDATE       = 2'd2;
    localparam logic [1:0] FUNC_NONE         = 2'd3;

    // half height of a disc column: floor(sqrt(r*r - adx*adx))
    function automatic logic [RAD_W-1:0] half_len(input logic [RAD_W-1:0] r,
                                                  input logic [RAD_W-1:0] adx);
        logic [RAD_W-1:0] h;
        h = '0;
        case ({r, adx})
            {3'd1, 3'd0}: h = 3'd1;
            {3'd2, 3'd0}: h = 3'd2;
            {3'd2, 3'd1}: h = 3'd1;
            {3'd3, 3'd0}: h = 3'd3;
            {3'd3, 3'd1}: h = 3'd2;
            {3'd3, 3'd2}: h = 3'd2;
            {3'd4, 3'd0}: h = 3'd4;
            {3'd4, 3'd1}: h = 3'd3;
            {3'd4, 3'd2}: h = 3'd3;
            {3'd4, 3'd3}: h = 3'd2;
            default:      h = 3'd0;
        endcase
        return h;
    endfunction

    // cells in the disc, centre included
    function automatic logic [CNT_W-1:0] disc_count(input logic [RAD_W-1:0] r);
        logic [CNT_W-1:0] c;
        case (r)
            3'd1:    c = 6'd5;
            3'd2:    c = 6'd13;
            3'd3:    c = 6'd29;
            3'd4:    c = 6'd49;
            default: c = 6'd1;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/disc_neighbourhood_dissimilarity_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disc_neighbourhood_dissimilarity_top
// Toroidal marker grid with disc-shaped local dissimilarity updates.
// ----------------------------------------------------------------------------
// After reset the block sweeps the marker store to zero, one entry a cycle;
// in_stall stays high meanwhile, configuration writes are taken at any time.
// A request writes a marker (func 0), writes then updates (func 1) or only
// updates (func 2); func 3 is taken and dropped. An update walks every focus
// cell of the disc around the cell, X offset outer, Y inner, and for each one
// reads the focus marker, then one neighbour marker per cycle through the
// single store read port, accumulating absolute differences, then hands the
// sum to a one bit per cycle divider. Cell coordinates are first reduced
// modulo the grid size by repeated subtraction. The block takes one request
// at a time; a finished result waits in the output register while the next
// focus cell is worked on.
// ----------------------------------------------------------------------------
module disc_neighbourhood_dissimilarity_top #(
    parameter int MAX_WIDTH   = dnd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = dnd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS  = dnd_pkg::DEF_MAX_RADIUS,
    parameter int MARKER_BITS = dnd_pkg::DEF_MARKER_BITS
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // configuration
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [dnd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [dnd_pkg::CFG_DAT_W-1:0] cfg_data,
    // requests
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire  [1:0]                    func,
    input  wire  [5:0]                    cell_x,
    input  wire  [5:0]                    cell_y,
    input  wire  [15:0]                   new_marker,
    // results
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic [5:0]                    focus_x,
    output logic [5:0]                    focus_y,
    output logic [15:0]                   local_density,
    output logic                          last
);
    import dnd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = MARKER_BITS + SUMX_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MODX, S_MODY, S_WRITE, S_FSTART, S_FWAIT,
        S_NEIGH, S_DRAIN, S_DIV, S_DIVW
    } state_t;

    typedef logic signed [OFS_W-1:0] ofs_t;

    // configuration registers
    logic [6:0]       grid_width_reg;
    logic [6:0]       grid_height_reg;
    logic [RAD_W-1:0] density_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg     <= 7'd64;
            grid_height_reg    <= 7'd64;
            density_radius_reg <= 3'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:     grid_width_reg     <= cfg_data;
                CFG_GRID_HEIGHT:    grid_height_reg    <= cfg_data;
                CFG_DENSITY_RADIUS: density_radius_reg <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry, saturated into range
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [RAD_W-1:0] r_eff;
    ofs_t             r_s;

    always_comb
    begin
        if (grid_width_reg < 7'd4)
            w_eff = DIM_W'(4);
        else if (DIM_W'(grid_width_reg) > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(grid_width_reg);
        if (grid_height_reg < 7'd4)
            h_eff = DIM_W'(4);
        else if (DIM_W'(grid_height_reg) > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(grid_height_reg);
        if (density_radius_reg == '0)
            r_eff = RAD_W'(1);
        else if (density_radius_reg > RAD_W'(MAX_RADIUS))
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = density_radius_reg;
        r_s = ofs_t'({1'b0, r_eff});
    end

    // wrap c + d onto 0..n-1; |d| <= 4 <= n so one correction suffices
    function automatic logic [COORD_W-1:0] wrap_add(input logic [COORD_W-1:0] c,
                                                    input ofs_t d,
                                                    input logic [DIM_W-1:0] n);
        logic signed [DIM_W+1:0] v;
        v = $signed({2'b00, 1'b0, c}) + (DIM_W+2)'(d);
        if (v < 0)
            v = v + $signed({1'b0, 1'b0, n});
        else if (v >= $signed({1'b0, 1'b0, n}))
            v = v - $signed({1'b0, 1'b0, n});
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
        return AW'(int'(x) * MAX_HEIGHT + int'(y));
    endfunction

    function automatic logic [RAD_W-1:0] abs_ofs(input ofs_t d);
        ofs_t a;
        a = (d < 0) ? -d : d;
        return a[RAD_W-1:0];
    endfunction

    function automatic ofs_t half_s(input logic [RAD_W-1:0] r, input ofs_t d);
        return ofs_t'({1'b0, half_len(r, abs_ofs(d))});
    endfunction

    // sequencer state
    state_t               state_reg,  state_next;
    logic [AW-1:0]        clr_reg,    clr_next;
    logic [1:0]           func_reg,   func_next;
    logic [COORD_W-1:0]   cx_reg,     cx_next;
    logic [COORD_W-1:0]   cy_reg,     cy_next;
    logic [MARKER_BITS-1:0] mk_reg,   mk_next;
    ofs_t                 dx_reg,     dx_next;
    ofs_t                 dy_reg,     dy_next;
    ofs_t                 ex_reg,     ex_next;
    ofs_t                 ey_reg,     ey_next;
    logic [COORD_W-1:0]   fx_reg,     fx_next;
    logic [COORD_W-1:0]   fy_reg,     fy_next;
    logic [MARKER_BITS-1:0] a_reg,    a_next;
    logic [SW-1:0]        sum_reg,    sum_next;
    logic                 pend_reg,   pend_next;
    logic                 ov_reg,     ov_next;
    logic [5:0]           ofx_reg,    ofx_next;
    logic [5:0]           ofy_reg,    ofy_next;
    logic [15:0]          od_reg,     od_next;
    logic                 olast_reg,  olast_next;

    // store ports
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [MARKER_BITS-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [MARKER_BITS-1:0] mem_rdata;

    // divider
    logic          div_start;
    logic          div_busy;
    logic [SW-1:0] div_q;

    logic [COORD_W-1:0]     nx, ny, wfx, wfy;
    logic [MARKER_BITS-1:0] adiff;
    logic                   out_free;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = ov_reg;
    assign focus_x       = ofx_reg;
    assign focus_y       = ofy_reg;
    assign local_density = od_reg;
    assign last          = olast_reg;

    assign out_free = !ov_reg || !out_stall;
    assign wfx      = wrap_add(cx_reg, dx_reg, w_eff);
    assign wfy      = wrap_add(cy_reg, dy_reg, h_eff);
    assign nx       = wrap_add(fx_reg, ex_reg, w_eff);
    assign ny       = wrap_add(fy_reg, ey_reg, h_eff);
    assign adiff    = (a_reg >= mem_rdata) ? (a_reg - mem_rdata) : (mem_rdata - a_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        func_next  = func_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        mk_next    = mk_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        a_next     = a_reg;
        sum_next   = sum_reg;
        pend_next  = 1'b0;
        ov_next    = ov_reg && out_stall;
        ofx_next   = ofx_reg;
        ofy_next   = ofy_reg;
        od_next    = od_reg;
        olast_next = olast_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr_of(cx_reg, cy_reg);
        mem_wdata  = mk_reg;
        mem_raddr  = addr_of(nx, ny);
        div_start  = 1'b0;

        // neighbour data arrives in the cycle after its address
        if (pend_reg)
        begin
            sum_next = sum_reg + SW'(adiff);
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    cx_next   = COORD_W'(cell_x);
                    cy_next   = COORD_W'(cell_y);
                    mk_next   = MARKER_BITS'(new_marker);
                    if (func != FUNC_NONE)
                        state_next = S_MODX;
                end
            end
            S_MODX:
            begin
                if ({1'b0, cx_reg} >= w_eff)
                    cx_next = COORD_W'({1'b0, cx_reg} - w_eff);
                else
                    state_next = S_MODY;
            end
            S_MODY:
            begin
                if ({1'b0, cy_reg} >= h_eff)
                    cy_next = COORD_W'({1'b0, cy_reg} - h_eff);
                else
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we  = (func_reg != FUNC_UPDATE);
                dx_next = -r_s;
                dy_next = '0;                 // the outermost column is one cell
                if (func_reg == FUNC_WRITE)
                    state_next = S_IDLE;
                else
                    state_next = S_FSTART;
            end
            S_FSTART:
            begin
                mem_raddr  = addr_of(wfx, wfy);
                fx_next    = wfx;
                fy_next    = wfy;
                ex_next    = -r_s;
                ey_next    = '0;
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                a_next     = mem_rdata;
                sum_next   = '0;
                state_next = S_NEIGH;
            end
            S_NEIGH:
            begin
                pend_next = !((nx == fx_reg) && (ny == fy_reg));
                if (ey_reg == half_s(r_eff, ex_reg))
                begin
                    if (ex_reg == r_s)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        ex_next = ex_reg + 1'b1;
                        ey_next = -half_s(r_eff, ex_reg + 1'b1);
                    end
                end
                else
                begin
                    ey_next = ey_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (!div_busy && out_free)
                begin
                    ov_next    = 1'b1;
                    ofx_next   = fx_reg[5:0];
                    ofy_next   = fy_reg[5:0];
                    od_next    = 16'(div_q);
                    olast_next = 1'b0;
                    if (dy_reg == half_s(r_eff, dx_reg))
                    begin
                        if (dx_reg == r_s)
                        begin
                            olast_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            dx_next    = dx_reg + 1'b1;
                            dy_next    = -half_s(r_eff, dx_reg + 1'b1);
                            state_next = S_FSTART;
                        end
                    end
                    else
                    begin
                        dy_next    = dy_reg + 1'b1;
                        state_next = S_FSTART;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        mk_reg    <= mk_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        a_reg     <= a_next;
        sum_reg   <= sum_next;
        ofx_reg   <= ofx_next;
        ofy_reg   <= ofy_next;
        od_reg    <= od_next;
        olast_reg <= olast_next;
    end

    dnd_mem #(
        .DEPTH (DEPTH),
        .DW    (MARKER_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dnd_div #(
        .NW (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (disc_count(r_eff)),
        .busy     (div_busy),
        .quotient (div_q)
    );

endmodule
`default_nettype wire

### hdl/dnd_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_mem
// Marker store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dnd_mem #(
    parameter int DEPTH = 4096,
    parameter int DW    = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [DW-1:0]            wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hdl/dnd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dnd_div #(
    parameter int NW = 22
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire  [NW-1:0]            dividend,
    input  wire  [dnd_pkg::CNT_W-1:0] divisor,
    output logic                     busy,
    output logic [NW-1:0]            quotient
);
    import dnd_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic [NW-1:0]    q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [CNT_W:0]   trial;

    assign trial    = {rem_reg, q_reg[NW-1]};
    assign busy     = busy_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= CNT_W'(trial - {1'b0, dvs_reg});
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CNT_W-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Neighbourhood dissimilarity block testbench
// Drives marker writes and disc updates into the block, keeps a grid model of
// its own and checks every density result in order. It runs through several
// grid and radius settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dnd_pkg::*;

    // ------------------------------------------------------------------------
    // Density scoreboard: a grid model and the queue of expected results
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [5:0]  fx;
        logic [5:0]  fy;
        logic [15:0] dens;
        logic        fin;
    } density_t;

    class density_board;
        logic [15:0] grid [64][64];
        logic [6:0]  width_reg, height_reg;
        logic [2:0]  radius_reg;
        density_t    pending [$];
        int          mismatches;

        function void clear();
            foreach (grid[i, j]) grid[i][j] = '0;
            width_reg = 7'd64;
            height_reg = 7'd64;
            radius_reg = 3'd2;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] val);
            if (idx == CFG_GRID_WIDTH) width_reg = val;
            else if (idx == CFG_GRID_HEIGHT) height_reg = val;
            else if (idx == CFG_DENSITY_RADIUS) radius_reg = val[2:0];
        endfunction

        function int wrap(int c, int d, int n);
            int v;
            v = c + d;
            while (v < 0) v += n;
            while (v >= n) v -= n;
            return v;
        endfunction

        // note an accepted request and queue the results it causes
        function void note_request(logic [1:0] f, logic [5:0] x, logic [5:0] y,
                                   logic [15:0] m);
            int w, h, r, cx, cy, cnt, fx, fy, nx, ny;
            int half [9];
            longint sum, a, b;
            density_t e;
            w = width_reg < 4 ? 4 : (width_reg > 64 ? 64 : width_reg);
            h = height_reg < 4 ? 4 : (height_reg > 64 ? 64 : height_reg);
            r = radius_reg < 1 ? 1 : (radius_reg > 4 ? 4 : radius_reg);
            cx = x % w;
            cy = y % h;
            if (f == FUNC_NONE) return;
            if (f != FUNC_UPDATE) grid[cx][cy] = m;
            if (f == FUNC_WRITE) return;
            cnt = 0;
            for (int dx = -r; dx <= r; dx++)
            begin
                int s;
                s = 0;
                while ((s + 1) * (s + 1) <= r * r - dx * dx) s++;
                half[dx + r] = s;
                cnt += 2 * s + 1;
            end
            for (int dx = -r; dx <= r; dx++)
                for (int dy = -half[dx + r]; dy <= half[dx + r]; dy++)
                begin
                    fx = wrap(cx, dx, w);
                    fy = wrap(cy, dy, h);
                    a = longint'(grid[fx][fy]);
                    sum = 0;
                    for (int ex = -r; ex <= r; ex++)
                        for (int ey = -half[ex + r]; ey <= half[ex + r]; ey++)
                        begin
                            nx = wrap(fx, ex, w);
                            ny = wrap(fy, ey, h);
                            if (nx == fx && ny == fy) continue;
                            b = longint'(grid[nx][ny]);
                            sum += a >= b ? a - b : b - a;
                        end
                    e.fx = 6'(fx);
                    e.fy = 6'(fy);
                    e.dens = 16'(sum / cnt);
                    e.fin = (dx == r && dy == half[dx + r]);
                    pending = {pending, e};
                end
        endfunction

        function void check_result(density_t got);
            density_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p at %0t", got, $time);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch at %0t: expected x=%0d y=%0d d=%0d ",
                              "last=%0b, got x=%0d y=%0d d=%0d last=%0b"},
                             $time, e.fx, e.fy, e.dens, e.fin,
                             got.fx, got.fy, got.dens, got.fin);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [5:0] cell_x = '0, cell_y = '0;
    logic [15:0] new_marker = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [5:0] focus_x, focus_y;
    logic [15:0] local_density;
    logic last;

    // idle percentages for sender and receiver
    int send_idle = 0;
    int recv_idle = 0;
    density_board board;

    always #5 clk = ~clk;

    disc_neighbourhood_dissimilarity_top dut (.*);

    // receiver: random stall, results checked at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result('{focus_x, focus_y, local_density, last});
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // one request, with a random gap before it; valid stays up afterwards
    // until the next gap or the next drain
    task automatic send_request(logic [1:0] f, logic [5:0] x, logic [5:0] y,
                                logic [15:0] m);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        cell_x <= x;
        cell_y <= y;
        new_marker <= m;
        do @(posedge clk); while (in_stall);
        board.note_request(f, x, y, m);
    endtask

    // wait until every result is in; a write-only request may still be busy
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic random_burst(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            // mostly writes so updates see varied markers, some updates
            send_request(k < 55 ? FUNC_WRITE : k < 75 ? FUNC_WRITE_UPDATE :
                         k < 95 ? FUNC_UPDATE : FUNC_NONE,
                         6'($urandom), 6'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, field extremes, every func code
        send_request(FUNC_UPDATE, 6'd0, 6'd0, 16'h0);
        send_request(FUNC_WRITE, 6'd63, 6'd63, 16'hFFFF);
        send_request(FUNC_WRITE_UPDATE, 6'd0, 6'd0, 16'hFFFF);
        send_request(FUNC_UPDATE, 6'd63, 6'd63, 16'h1234);
        send_request(FUNC_NONE, 6'd5, 6'd5, 16'hAAAA);
        send_request(FUNC_WRITE_UPDATE, 6'd21, 6'd42, 16'h5555);
        drain();

        // small grid, widest disc: wrap-around revisits and self-skips
        write_reg(CFG_GRID_WIDTH, 7'd4);
        write_reg(CFG_GRID_HEIGHT, 7'd4);
        write_reg(CFG_DENSITY_RADIUS, 7'd4);
        send_request(FUNC_WRITE, 6'd63, 6'd62, 16'h8001);
        send_request(FUNC_WRITE_UPDATE, 6'd1, 6'd2, 16'h00FF);
        drain();
        // out-of-range settings saturate
        write_reg(CFG_GRID_WIDTH, 7'd0);
        write_reg(CFG_GRID_HEIGHT, 7'd127);
        write_reg(CFG_DENSITY_RADIUS, 7'd0);
        send_request(FUNC_WRITE_UPDATE, 6'd3, 6'd63, 16'h0100);
        drain();
        write_reg(CFG_DENSITY_RADIUS, 7'd7);
        send_request(FUNC_UPDATE, 6'd2, 6'd10, 16'h0);
        drain();

        // random phases: sender/receiver idling swapped, then none
        send_idle = 32; recv_idle = 57;
        write_reg(CFG_GRID_WIDTH, 7'd6);
        write_reg(CFG_GRID_HEIGHT, 7'd5);
        write_reg(CFG_DENSITY_RADIUS, 7'd1);
        random_burst(140);
        drain();
        send_idle = 57; recv_idle = 32;
        write_reg(CFG_GRID_WIDTH, 7'd13);
        write_reg(CFG_GRID_HEIGHT, 7'd64);
        write_reg(CFG_DENSITY_RADIUS, 7'd3);
        random_burst(140);
        drain();
        send_idle = 0; recv_idle = 0;
        write_reg(CFG_GRID_WIDTH, 7'd64);
        write_reg(CFG_GRID_HEIGHT, 7'd9);
        write_reg(CFG_DENSITY_RADIUS, 7'd2);
        random_burst(140);
        drain();

        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
